[src/odometer_speedometer_top_macros.svh]
// assertion macros shared by the checker
`ifndef ODOMETER_SPEEDOMETER_TOP_MACROS_SVH
`define ODOMETER_SPEEDOMETER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ODOSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometer_speedometer assertion failed");

// next-cycle implication, disabled while in reset
`define ODOSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometer_speedometer assertion failed");

`endif

[src/odosp_pkg.sv]
`default_nettype none
package odosp_pkg;

	localparam int PERIOD_BITS = 16;

	localparam int TV_W      = 8;
	localparam int PPU_W     = 10;
	localparam int DIST_W    = 20;
	localparam int SPK_W     = 16;
	localparam int CNT8_W    = 8;
	localparam int SPEED_W   = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 20;
	localparam int IN_W      = 8;
	localparam int OUT_W     = 56;
	localparam int DIST_DIGITS  = 6;
	localparam int SPEED_DIGITS = 3;

	localparam int DIV_STEPS = SPK_W;
	localparam int BCD_STEPS = DIST_W;
	localparam int CNT_W     = 5;

	localparam logic [DIST_W-1:0]  DIST_MAX       = 20'd999999;
	localparam logic [PPU_W-1:0]   PPU_RESET      = 10'd740;
	localparam logic [DIST_W-1:0]  LIMIT_RESET    = 20'h927C0;
	localparam logic [SPK_W-1:0]   SPK_RESET      = 16'd18998;
	localparam logic [DIST_W-1:0]  START_RESET    = 20'd599984;
	localparam logic [CNT8_W-1:0]  PHASE_RESET    = 8'd250;
	localparam logic [CNT8_W-1:0]  OVF_MAX        = 8'd255;
	localparam logic [SPEED_W-1:0] SPEED_MAX      = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_PPU   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPK   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START = 8'd3;

	localparam logic CMD_OVERFLOW = 1'b0;
	localparam logic CMD_PULSE    = 1'b1;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_step;
		logic bcd_init;
		logic bcd_step;
		logic out_load;
	} odosp_cmd_t;

	function automatic logic [3:0] bcd_adj(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage
`default_nettype wire

[src/odosp_ctrl.sv]
`default_nettype none
module odosp_ctrl
	import odosp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output odosp_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UPD  = 5'b00010,
		S_DIV  = 5'b00100,
		S_BCD  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             slot_free;

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				cnt_d      = '0;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_BCD;
				end
			end
			S_BCD: begin
				cmd.bcd_init = (cnt_q == '0);
				cmd.bcd_step = (cnt_q != '0);
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BCD_STEPS)) begin
					cnt_d   = '0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/odosp_dp.sv]
`default_nettype none
module odosp_dp
	import odosp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire odosp_cmd_t           cmd,
	input  wire logic                 in_cmd,
	input  wire logic [IN_W-1:0]      in_timer,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic [OUT_W-1:0]          out_data
);

	localparam int PW = PERIOD_BITS;
	localparam int CW = (PW > 17) ? PW : 17;
	localparam logic [PW-1:0] PMAX = '1;

	logic [PPU_W-1:0]   ppu_q;
	logic [DIST_W-1:0]  limit_q;
	logic [SPK_W-1:0]   spk_q;

	logic [PPU_W-1:0]   pre_q;
	logic [DIST_W-1:0]  dist_q;
	logic [CNT8_W-1:0]  phase_q;
	logic [CNT8_W-1:0]  ovf_q;
	logic [TV_W-1:0]    tstart_q;
	logic [PW-1:0]      period_q;
	logic               meas_q;
	logic               limit_hit_q;

	logic               cmd_q;
	logic [TV_W-1:0]    tv_q;

	logic [PW-1:0]      rem_q;
	logic [SPK_W-1:0]   quo_q;

	logic [DIST_W-1:0]  dbin_q;
	logic [DIST_W-1:0]  sbin_q;
	logic [4*DIST_DIGITS-1:0]  dbcd_q;
	logic [4*SPEED_DIGITS-1:0] sbcd_q;

	logic [OUT_W-1:0]   out_q;

	logic [PPU_W-1:0]   pre_inc;
	logic [DIST_W-1:0]  dist_inc;
	logic [DIST_W-1:0]  dist_sat;
	logic [CNT8_W-1:0]  phase_inc;
	logic [17:0]        pdiff;
	logic [PW:0]        shifted;
	logic               fits;
	logic [SPEED_W-1:0] speed;
	logic [DIST_W-1:0]  cfg_dist_sat;
	logic [4*DIST_DIGITS-1:0]  dbcd_adj;
	logic [4*SPEED_DIGITS-1:0] sbcd_adj;

	assign pre_inc      = pre_q + 1'b1;
	assign dist_inc     = dist_q + 1'b1;
	assign dist_sat     = (dist_inc > DIST_MAX) ? DIST_MAX : dist_inc;
	assign phase_inc    = phase_q + 1'b1;
	assign pdiff        = {2'b0, ovf_q, tv_q} - {10'b0, tstart_q};
	assign shifted      = {rem_q, quo_q[SPK_W-1]};
	assign fits         = shifted >= {1'b0, period_q};
	assign cfg_dist_sat = (cfg_data > DIST_MAX) ? DIST_MAX : cfg_data;

	always_comb begin
		if (period_q == '0) begin
			speed = '0;
		end else if (quo_q > SPK_W'(SPEED_MAX)) begin
			speed = SPEED_MAX;
		end else begin
			speed = quo_q[SPEED_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < DIST_DIGITS; i++) begin
			dbcd_adj[4*i +: 4] = bcd_adj(dbcd_q[4*i +: 4]);
		end
		for (int i = 0; i < SPEED_DIGITS; i++) begin
			sbcd_adj[4*i +: 4] = bcd_adj(sbcd_q[4*i +: 4]);
		end
	end

	// config and odometer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q       <= PPU_RESET;
			limit_q     <= LIMIT_RESET;
			spk_q       <= SPK_RESET;
			pre_q       <= '0;
			dist_q      <= START_RESET;
			phase_q     <= PHASE_RESET;
			ovf_q       <= '0;
			tstart_q    <= '0;
			period_q    <= '0;
			meas_q      <= 1'b0;
			limit_hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PPU:   ppu_q   <= cfg_data[PPU_W-1:0];
					REG_LIMIT: limit_q <= cfg_data[DIST_W-1:0];
					REG_SPK:   spk_q   <= cfg_data[SPK_W-1:0];
					REG_START: dist_q  <= cfg_dist_sat;
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (cmd_q == CMD_OVERFLOW) begin
					if (meas_q && ovf_q != OVF_MAX) begin
						ovf_q <= ovf_q + 1'b1;
					end
				end else if (!limit_hit_q) begin
					if (pre_inc >= ppu_q) begin
						pre_q  <= '0;
						dist_q <= dist_sat;
						if (dist_sat >= limit_q) begin
							limit_hit_q <= 1'b1;
						end
					end else begin
						pre_q <= pre_inc;
					end
					phase_q <= phase_inc;
					if (phase_inc == '0) begin
						ovf_q    <= '0;
						tstart_q <= tv_q;
						meas_q   <= 1'b1;
					end else if (phase_inc == CNT8_W'(1) && meas_q) begin
						meas_q <= 1'b0;
						if (pdiff[17]) begin
							period_q <= '0;
						end else if (CW'(pdiff[16:0]) > CW'(PMAX)) begin
							period_q <= PMAX;
						end else begin
							period_q <= PW'(pdiff[16:0]);
						end
					end
				end
			end
		end
	end

	// input capture, divider, binary to bcd, output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			tv_q  <= in_timer;
		end
		if (cmd.update) begin
			rem_q <= '0;
			quo_q <= spk_q;
		end else if (cmd.div_step) begin
			rem_q <= fits ? PW'(shifted - {1'b0, period_q}) : shifted[PW-1:0];
			quo_q <= {quo_q[SPK_W-2:0], fits};
		end
		if (cmd.bcd_init) begin
			dbin_q <= dist_q;
			sbin_q <= {{(DIST_W-SPEED_W){1'b0}}, speed};
			dbcd_q <= '0;
			sbcd_q <= '0;
		end else if (cmd.bcd_step) begin
			dbcd_q <= {dbcd_adj[4*DIST_DIGITS-2:0], dbin_q[DIST_W-1]};
			sbcd_q <= {sbcd_adj[4*SPEED_DIGITS-2:0], sbin_q[DIST_W-1]};
			dbin_q <= {dbin_q[DIST_W-2:0], 1'b0};
			sbin_q <= {sbin_q[DIST_W-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			out_q <= {1'b0, limit_hit_q, sbcd_q[3:0], sbcd_q[7:4], sbcd_q[9:8],
				dbcd_q[3:0], dbcd_q[7:4], dbcd_q[11:8], dbcd_q[15:12],
				dbcd_q[19:16], dbcd_q[23:20], dist_q};
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

[src/odometer_speedometer_top.sv]
// an accepted request runs the update, divide and bcd states, then done,
// which waits while the output is stalled; requests are taken one at a time
// divide runs a 16-step restoring divider, bcd a 20-step bcd shifter
// reset: asynchronous active low; config and odometer state return to their defaults
// output register holds a result until taken while the next request is accepted
`default_nettype none
module odometer_speedometer_top
	import odosp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // timer_value
	input  wire logic                 s_tuser,   // cmd
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// distance, dist_d5, dist_d4, dist_d3, dist_d2, dist_d1, dist_d0,
	// speed_d2, speed_d1, speed_d0, limit_flag, zero pad
	output logic [OUT_W-1:0]          m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	odosp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	odosp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	odosp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_cmd    (s_tuser),
		.in_timer  (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

[src/odosp_checker.sv]
`default_nettype none
`include "odometer_speedometer_top_macros.svh"
module odosp_checker
	import odosp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [OUT_W-1:0]     m_tdata
);

	logic in_acc;
	logic digits_ok;

	assign in_acc = s_tvalid && s_tready;
	assign digits_ok = (m_tdata[23:20] <= 4'd9) && (m_tdata[27:24] <= 4'd9) &&
		(m_tdata[31:28] <= 4'd9) && (m_tdata[35:32] <= 4'd9) &&
		(m_tdata[39:36] <= 4'd9) && (m_tdata[43:40] <= 4'd9) &&
		(m_tdata[45:44] <= 2'd2) && (m_tdata[49:46] <= 4'd9) &&
		(m_tdata[53:50] <= 4'd9) && !m_tdata[55];

	`ODOSP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`ODOSP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	`ODOSP_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_tready)
	`ODOSP_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(m_tvalid))
	`ODOSP_ASSERT_NOW(a_digits_decimal, m_tvalid, digits_ok)

endmodule

bind odometer_speedometer_top odosp_checker u_chk (.*);
`default_nettype wire

[sim/odometer_speedometer_top_tb.sv]
`timescale 1ns / 100ps
module odometer_speedometer_top_tb
	import odosp_pkg::*;
;
	localparam int PERIOD_MAX = (1 << PERIOD_BITS) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic               pad;
		logic               limit_flag;
		logic [3:0]         speed_d0;
		logic [3:0]         speed_d1;
		logic [1:0]         speed_d2;
		logic [3:0]         dist_d0;
		logic [3:0]         dist_d1;
		logic [3:0]         dist_d2;
		logic [3:0]         dist_d3;
		logic [3:0]         dist_d4;
		logic [3:0]         dist_d5;
		logic [DIST_W-1:0]  distance;
	} reading_t;

	typedef struct packed {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic                 cmd;
		logic [CFG_W-1:0]     value;
		logic                 typed;
		logic [DIST_W-1:0]    want_dist;
		logic [SPEED_W-1:0]   want_speed;
		logic                 want_flag;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 s_tuser = CMD_OVERFLOW;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	odometer_speedometer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// odometer settings and state as the block should hold them
	logic [PPU_W-1:0]       ppu_r = PPU_RESET;
	logic [DIST_W-1:0]      limit_r = LIMIT_RESET;
	logic [SPK_W-1:0]       spk_r = SPK_RESET;
	logic [PPU_W-1:0]       prescale = '0;
	logic [DIST_W-1:0]      odo = START_RESET;
	logic [CNT8_W-1:0]      phase = PHASE_RESET;
	logic [CNT8_W-1:0]      ovf_cnt = '0;
	logic [TV_W-1:0]        t_open = '0;
	logic [PERIOD_BITS-1:0] period_r = '0;
	logic                   measuring = 1'b0;
	logic                   limit_hit = 1'b0;

	reading_t expected_readings [$];
	int  mismatches = 0;
	int  send_idle = 8;
	int  recv_idle = 87;
	int  windows_seen = 0;
	int  hold_left = 0;
	bit  hold_wanted = 1'b0;
	bit  hold_done = 1'b0;

	function automatic logic [DIST_W-1:0] clamp_distance(input logic [DIST_W-1:0] v);
		return (v > DIST_MAX) ? DIST_MAX : v;
	endfunction

	function automatic reading_t make_reading(input logic [DIST_W-1:0] dist_val,
			input logic [SPEED_W-1:0] spd, input logic flag);
		reading_t r;
		int unsigned d;
		r = '0;
		r.distance = dist_val;
		d = dist_val;
		r.dist_d0 = 4'(d % 10); d = d / 10;
		r.dist_d1 = 4'(d % 10); d = d / 10;
		r.dist_d2 = 4'(d % 10); d = d / 10;
		r.dist_d3 = 4'(d % 10); d = d / 10;
		r.dist_d4 = 4'(d % 10); d = d / 10;
		r.dist_d5 = 4'(d % 10);
		r.speed_d2 = 2'(spd / 100);
		r.speed_d1 = 4'((spd / 10) % 10);
		r.speed_d0 = 4'(spd % 10);
		r.limit_flag = flag;
		return r;
	endfunction

	function automatic reading_t advance_odometer(input logic cmd, input logic [TV_W-1:0] tv);
		int p;
		int unsigned q;
		logic [SPEED_W-1:0] spd;
		if (cmd == CMD_OVERFLOW) begin
			if (measuring && ovf_cnt != OVF_MAX)
				ovf_cnt = ovf_cnt + 8'd1;
		end else if (!limit_hit) begin
			prescale = prescale + 10'd1;
			if (prescale >= ppu_r) begin
				prescale = '0;
				odo = clamp_distance(odo + 20'd1);
				if (odo >= limit_r)
					limit_hit = 1'b1;
			end
			phase = phase + 8'd1;
			if (phase == 8'd0) begin
				ovf_cnt = '0;
				t_open = tv;
				measuring = 1'b1;
			end else if (phase == 8'd1 && measuring) begin
				p = int'(ovf_cnt) * 256 + int'(tv) - int'(t_open);
				measuring = 1'b0;
				if (p < 0)
					period_r = '0;
				else if (p > PERIOD_MAX)
					period_r = PERIOD_BITS'(PERIOD_MAX);
				else
					period_r = PERIOD_BITS'(p);
			end
		end
		spd = '0;
		if (period_r != 0) begin
			q = spk_r / period_r;
			spd = (q > 255) ? SPEED_MAX : SPEED_W'(q);
		end
		return make_reading(odo, spd, limit_hit);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic check_reading(input reading_t got);
		reading_t want;
		if (expected_readings.size() == 0) begin
			report_mismatch("result with none pending, distance", got.distance, 0);
		end else begin
			want = expected_readings.pop_front();
			if (got.distance != want.distance)
				report_mismatch("distance", got.distance, want.distance);
			if (got.dist_d5 != want.dist_d5) report_mismatch("dist_d5", got.dist_d5, want.dist_d5);
			if (got.dist_d4 != want.dist_d4) report_mismatch("dist_d4", got.dist_d4, want.dist_d4);
			if (got.dist_d3 != want.dist_d3) report_mismatch("dist_d3", got.dist_d3, want.dist_d3);
			if (got.dist_d2 != want.dist_d2) report_mismatch("dist_d2", got.dist_d2, want.dist_d2);
			if (got.dist_d1 != want.dist_d1) report_mismatch("dist_d1", got.dist_d1, want.dist_d1);
			if (got.dist_d0 != want.dist_d0) report_mismatch("dist_d0", got.dist_d0, want.dist_d0);
			if (got.speed_d2 != want.speed_d2)
				report_mismatch("speed_d2", got.speed_d2, want.speed_d2);
			if (got.speed_d1 != want.speed_d1)
				report_mismatch("speed_d1", got.speed_d1, want.speed_d1);
			if (got.speed_d0 != want.speed_d0)
				report_mismatch("speed_d0", got.speed_d0, want.speed_d0);
			if (got.limit_flag != want.limit_flag)
				report_mismatch("limit_flag", got.limit_flag, want.limit_flag);
		end
	endtask

	// result side: check, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_reading(m_tdata);
		if (hold_wanted && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_item(input logic cmd, input logic [TV_W-1:0] tv,
			input logic use_typed = 1'b0, input reading_t typed = '0);
		reading_t predicted;
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= tv;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = advance_odometer(cmd, tv);
		expected_readings.push_back(use_typed ? typed : predicted);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PPU:   ppu_r = val[PPU_W-1:0];
			REG_LIMIT: limit_r = val;
			REG_SPK:   spk_r = val[SPK_W-1:0];
			REG_START: odo = clamp_distance(val);
			default: ;
		endcase
	endtask

	task automatic random_items(input int n);
		int sent;
		int run;
		int j;
		logic [TV_W-1:0] tv;
		sent = 0;
		while (sent < n) begin
			if (measuring && !limit_hit) begin
				// open window: overflows then the closing pulse
				if (windows_seen == 0 || $urandom_range(0, 5) == 0)
					run = $urandom_range(256, 300);
				else
					run = $urandom_range(0, 2);
				windows_seen++;
				for (j = 0; j < run; j++)
					send_item(CMD_OVERFLOW, TV_W'($urandom_range(0, 255)));
				tv = TV_W'($urandom_range(0, 255));
				if (run == 0 && $urandom_range(0, 1) == 1)
					tv = TV_W'($urandom_range(0, t_open));
				send_item(CMD_PULSE, tv);
				sent += run + 1;
			end else begin
				send_item(($urandom_range(0, 99) < 85) ? CMD_PULSE : CMD_OVERFLOW,
					TV_W'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	task automatic write_all(input logic [PPU_W-1:0] ppu_v, input logic [DIST_W-1:0] limit_v,
			input logic [SPK_W-1:0] spk_v, input logic [DIST_W-1:0] start_v);
		write_setting(REG_PPU, CFG_W'(ppu_v));
		write_setting(REG_LIMIT, limit_v);
		write_setting(REG_SPK, CFG_W'(spk_v));
		write_setting(REG_START, start_v);
	endtask

	task automatic run_phase(input logic [PPU_W-1:0] ppu_v, input logic [DIST_W-1:0] limit_v,
			input logic [SPK_W-1:0] spk_v, input logic [DIST_W-1:0] start_v, input int n);
		write_all(ppu_v, limit_v, spk_v, start_v);
		random_items(n);
	endtask

	step_t directed_plan [$] = '{
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'hFF, 1'b1, 20'd599984, 8'd0, 1'b0},
		'{1'b1, REG_PPU, CMD_OVERFLOW, 20'd1, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h00, 1'b1, 20'd599985, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'hFF, 1'b1, 20'd599986, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h55, 1'b1, 20'd599987, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'hAA, 1'b1, 20'd599988, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h01, 1'b1, 20'd599989, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'hC0, 1'b1, 20'd599990, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'h12, 1'b1, 20'd599990, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'h00, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h40, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'hFF, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_SPK, CMD_OVERFLOW, 20'hFFFF, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'h00, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_SPK, CMD_OVERFLOW, 20'd1, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'h33, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_UNUSED, CMD_OVERFLOW, 20'hFFFFF, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_UNUSED_TOP, CMD_OVERFLOW, 20'h00000, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_LIMIT, CMD_OVERFLOW, 20'hFFFFF, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b1, REG_START, CMD_OVERFLOW, 20'hFFFFF, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_OVERFLOW, 20'h00, 1'b1, 20'd999999, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h7F, 1'b1, 20'd999999, 8'd0, 1'b0},
		'{1'b1, REG_START, CMD_OVERFLOW, 20'd0, 1'b0, 20'd0, 8'd0, 1'b0},
		'{1'b0, REG_PPU, CMD_PULSE, 20'h80, 1'b1, 20'd1, 8'd0, 1'b0}
	};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write)
				write_setting(directed_plan[i].reg_idx, directed_plan[i].value);
			else
				send_item(directed_plan[i].cmd, directed_plan[i].value[TV_W-1:0],
					directed_plan[i].typed, make_reading(directed_plan[i].want_dist,
					directed_plan[i].want_speed, directed_plan[i].want_flag));
		end

		run_phase(PPU_W'($urandom_range(1, 4)), 20'hFFFFF, SPK_W'($urandom_range(1, 65535)),
			DIST_W'($urandom_range(0, 999999)), 450);

		send_idle = 87;
		recv_idle = 8;
		run_phase('0, DIST_MAX, 16'hFFFF, 20'd999000, 300);
		run_phase(10'd1023, DIST_MAX, 16'd1, 20'd0, 200);

		send_idle = 0;
		recv_idle = 0;
		write_all(10'd3, 20'hFFFFF, SPK_W'($urandom_range(1, 65535)), 20'd999950);
		hold_wanted = 1'b1;
		random_items(250);

		// limit reached either by counting or by a start already past it
		if ($urandom_range(0, 1) == 1)
			run_phase(10'd2, 20'd600, SPK_W'($urandom_range(1, 65535)), 20'd560, 200);
		else
			run_phase(10'd1, 20'd0, 16'hFFFF, DIST_W'($urandom_range(1, 999999)), 200);
		run_phase(10'd1, DIST_MAX, 16'd300, 20'hFFFFF, 30);

		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
